[rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int REG_PAGES_W = 7;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bpa_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } bpa_status_t;

  typedef enum logic {
    REG_BASE  = 1'b0,
    REG_PAGES = 1'b1
  } bpa_reg_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PREP,
    S_RNG,
    S_FREE,
    S_SCAN,
    S_MARK,
    S_ADDR,
    S_DONE
  } bpa_state_t;

endpackage

[rtl/bitmap_page_allocator_core.sv]
// steps: an allocate scans the page map for a free run and then marks the pages it
//   grants; a free checks its range and then clears the pages in it
// throughput: one request at a time, the page map is read or written one page per cycle
// reset: sync active low; clears config to base 0 / 56 pages, then a clearing pass
//   zeroes the page map before the first request is taken
module bitmap_page_allocator_core import bpa_pkg::*; #(
  parameter int MAX_PAGES  = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,    // request_bytes[31:0], free_address[95:32]
  input  logic                  in_tuser,    // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,   // granted_address
  output logic [1:0]            out_tuser,   // status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW    = (AW + 1 > REG_PAGES_W + 1) ? AW + 1 : REG_PAGES_W + 1;
  localparam int SHIFT = $clog2(PAGE_BYTES);
  localparam int NW    = 33 - SHIFT;
  localparam int SW    = NW + CW;
  localparam int RBW   = CW + SHIFT;

  bpa_state_t state_r, state_nxt;

  logic [63:0]            base_r;
  logic [REG_PAGES_W-1:0] pages_r;

  logic                   cmd_r;
  logic [31:0]            bytes_r;
  logic [63:0]            faddr_r;
  logic [NW-1:0]          need_r;
  logic [63:0]            offset_r;
  logic                   borrow_r;

  logic [CW-1:0]          ii_r, pidx_r, run_r, start_r, wi_r, end_r;
  logic                   pend_r;
  logic                   rd_q;

  logic [1:0]             res_status_r;
  logic [63:0]            res_addr_r;
  logic                   out_tvalid_r;
  logic [1:0]             out_status_r;
  logic [63:0]            out_addr_r;

  logic                   page_map [MAX_PAGES];

  logic [CW-1:0]          npages;
  logic [32:0]            need_sum;
  logic [NW-1:0]          need_calc;
  logic [64:0]            off_calc;
  logic                   alloc_ok;
  logic [RBW-1:0]         rb;
  logic                   oor;
  logic [CW-1:0]          first;
  logic [SW-1:0]          end_sum;
  logic [CW-1:0]          free_end;
  logic                   found, scan_fail;
  logic [CW-1:0]          found_start;
  logic                   mem_we, mem_wd;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic                   cfg_wr, out_load;

  assign npages = (CW'(pages_r) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pages_r);

  assign need_sum  = {1'b0, bytes_r} + 33'(PAGE_BYTES - 1);
  assign need_calc = need_sum[32:SHIFT];
  assign off_calc  = {1'b0, faddr_r} - {1'b0, base_r};
  assign alloc_ok  = (need_calc != '0) && (need_calc <= NW'(npages));

  // free range check, offset known not to exceed rb when the last term is looked at
  assign rb  = RBW'(npages) << SHIFT;
  assign oor = borrow_r || (offset_r > 64'(rb)) || (64'(bytes_r) > (64'(rb) - offset_r));
  assign first    = offset_r[SHIFT +: CW];
  assign end_sum  = SW'(first) + SW'(need_r);
  assign free_end = (end_sum > SW'(npages)) ? npages : end_sum[CW-1:0];

  // scan evaluates the page read issued in the previous cycle
  assign found_start = (run_r == '0) ? pidx_r : start_r;
  assign found       = pend_r && !rd_q && ((NW'(run_r) + NW'(1)) == need_r);
  assign scan_fail   = !pend_r && (ii_r >= npages);

  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (wi_r == CW'(MAX_PAGES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) state_nxt = S_PREP;
      S_PREP: begin
        if (cmd_r == CMD_FREE) state_nxt = S_RNG;
        else if (alloc_ok) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_RNG:  state_nxt = oor ? S_DONE : S_FREE;
      S_FREE: if (wi_r >= end_r) state_nxt = S_DONE;
      S_SCAN: begin
        priority if (found) state_nxt = S_MARK;
        else if (scan_fail) state_nxt = S_DONE;
      end
      S_MARK: if (wi_r + CW'(1) >= end_r) state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    unique case (state_r)
      S_CLR:  mem_we = 1'b1;
      S_IDLE: in_tready = 1'b1;
      S_FREE: mem_we = (wi_r < end_r);
      S_MARK: begin
        mem_we = 1'b1;
        mem_wd = 1'b1;
      end
      default: ;
    endcase
  end

  assign mem_wa = wi_r[AW-1:0];
  assign mem_ra = (ii_r < npages) ? ii_r[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) page_map[mem_wa] <= mem_wd;
    rd_q <= page_map[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      base_r       <= '0;
      pages_r      <= REG_PAGES_W'(56);
      wi_r         <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (bpa_reg_t'(cfg_paddr[3]) == REG_BASE) base_r <= cfg_pwdata;
        else pages_r <= cfg_pwdata[REG_PAGES_W-1:0];
      end
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_CLR: wi_r <= wi_r + CW'(1);
        S_IDLE: pend_r <= 1'b0;
        S_PREP: begin
          ii_r  <= '0;
          run_r <= '0;
        end
        S_RNG: begin
          wi_r  <= first;
          end_r <= free_end;
        end
        S_FREE: if (wi_r < end_r) wi_r <= wi_r + CW'(1);
        S_SCAN: begin
          if (ii_r < npages) begin
            pend_r <= 1'b1;
            pidx_r <= ii_r;
            ii_r   <= ii_r + CW'(1);
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (!rd_q) begin
              if (run_r == '0) start_r <= pidx_r;
              run_r <= run_r + CW'(1);
            end else begin
              run_r <= '0;
            end
          end
          if (found) begin
            start_r <= found_start;
            wi_r    <= found_start;
            end_r   <= found_start + need_r[CW-1:0];
          end
        end
        S_MARK: begin
          pend_r <= 1'b0;
          wi_r   <= wi_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser;
      bytes_r <= in_tdata[31:0];
      faddr_r <= in_tdata[95:32];
    end
    unique case (state_r)
      S_PREP: begin
        need_r       <= need_calc;
        offset_r     <= off_calc[63:0];
        borrow_r     <= off_calc[64];
        res_addr_r   <= '0;
        res_status_r <= (cmd_r == CMD_ALLOC && !alloc_ok) ? ST_NOSPACE : ST_OK;
      end
      S_RNG: if (oor) res_status_r <= ST_RANGE;
      S_SCAN: if (!found && scan_fail) res_status_r <= ST_NOSPACE;
      S_ADDR: res_addr_r <= base_r + (64'(start_r) << SHIFT);
      default: ;
    endcase
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (bpa_reg_t'(cfg_paddr[3]) == REG_BASE) ? base_r
                                                            : CFG_DATA_W'(pages_r);

  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("granted address nonzero on a failed request");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_DONE)
    else $error("result beat raised outside the done step");

  a_mark_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK |-> (end_r <= npages) && (wi_r < end_r))
    else $error("mark run reaches past the live region");

  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> run_r <= ii_r)
    else $error("free run longer than pages scanned");

  a_free_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FREE |-> end_r <= npages)
    else $error("free clears past the live region");

endmodule

[sim/bpa_grant_checker.sv]
`timescale 1ns / 1ps

module bpa_grant_checker import bpa_pkg::*; #(
  parameter int MAX_PAGES  = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [95:0]           in_tdata,    // request_bytes[31:0], free_address[95:32]
  input  logic                  in_tuser,    // cmd
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [63:0]           out_tdata,   // granted_address
  input  logic [1:0]            out_tuser,   // status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    results_seen,
  output int                    outstanding,
  output int                    granted_count,
  output int                    nospace_count,
  output int                    range_count
);

  typedef struct {
    bpa_cmd_t    cmd;
    logic [31:0] nbytes;
    logic [63:0] faddr;
    bpa_status_t status;
    logic [63:0] grant;
  } grant_t;

  grant_t                 pending_grants[$];
  logic [MAX_PAGES-1:0]   used_map;
  logic [63:0]            base_reg;
  logic [REG_PAGES_W-1:0] pages_reg;

  initial begin
    fail_count    = 0;
    results_seen  = 0;
    outstanding   = 0;
    granted_count = 0;
    nospace_count = 0;
    range_count   = 0;
  end

  // first-fit allocate or range-checked free against the local page map
  function automatic grant_t serve_request(bpa_cmd_t cmd, logic [31:0] nbytes,
                                           logic [63:0] faddr);
    grant_t      g;
    int unsigned live, run, first_free, p;
    logic [63:0] need, region_bytes, offset, first, q;
    bit          found;
    g.cmd    = cmd;
    g.nbytes = nbytes;
    g.faddr  = faddr;
    g.status = ST_OK;
    g.grant  = '0;
    live = (pages_reg > MAX_PAGES) ? MAX_PAGES : int'(pages_reg);
    need = (64'(nbytes) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES);
    if (cmd == CMD_ALLOC) begin
      run = 0;
      first_free = 0;
      found = 1'b0;
      if (need != 0 && need <= 64'(live)) begin
        for (p = 0; p < live && !found; p++) begin
          if (!used_map[p]) begin
            if (run == 0) first_free = p;
            run++;
            if (64'(run) == need) found = 1'b1;
          end else begin
            run = 0;
          end
        end
      end
      if (found) begin
        for (p = first_free; 64'(p) < 64'(first_free) + need; p++) used_map[p] = 1'b1;
        g.grant = base_reg + 64'(first_free) * 64'(PAGE_BYTES);
      end else begin
        g.status = ST_NOSPACE;
      end
    end else begin
      region_bytes = 64'(live) * 64'(PAGE_BYTES);
      offset = faddr - base_reg;
      if (faddr < base_reg || offset > region_bytes || 64'(nbytes) > region_bytes - offset) begin
        g.status = ST_RANGE;
      end else begin
        first = offset / 64'(PAGE_BYTES);
        // pages past the live count are left alone
        for (q = first; q < first + need; q++) begin
          if (q < 64'(live)) used_map[q] = 1'b0;
        end
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t exp;
    if (!rst_n) begin
      used_map  = '0;
      base_reg  = '0;
      pages_reg = REG_PAGES_W'(56);
      pending_grants.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (bpa_reg_t'(cfg_paddr[3]))
          REG_BASE:  base_reg = cfg_pwdata;
          REG_PAGES: pages_reg = cfg_pwdata[REG_PAGES_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_grants.size() == 0) begin
          report_mismatch($sformatf("result beat status %0d address %h with no request open",
                                    out_tuser, out_tdata));
        end else begin
          exp = pending_grants.pop_front();
          if (out_tuser !== exp.status)
            report_mismatch($sformatf("%s bytes %h addr %h: status %0d, expected %s",
                                      exp.cmd.name(), exp.nbytes, exp.faddr, out_tuser,
                                      exp.status.name()));
          if (out_tdata !== exp.grant)
            report_mismatch($sformatf("%s bytes %h addr %h: granted %h, expected %h",
                                      exp.cmd.name(), exp.nbytes, exp.faddr, out_tdata,
                                      exp.grant));
          case (exp.status)
            ST_OK:      if (exp.cmd == CMD_ALLOC) granted_count++;
            ST_NOSPACE: nospace_count++;
            default:    range_count++;
          endcase
        end
      end
      if (in_tvalid && in_tready)
        pending_grants.push_back(serve_request(bpa_cmd_t'(in_tuser), in_tdata[31:0],
                                               in_tdata[95:32]));
      outstanding = pending_grants.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bpa_pkg::*;

  localparam int MAX_PAGES   = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * MAX_PAGES + 32;
  localparam int HOLD_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [95:0]           in_tdata;    // request_bytes[31:0], free_address[95:32]
  logic                  in_tuser;    // cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [63:0]           out_tdata;   // granted_address
  logic [1:0]            out_tuser;   // status
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count, results_seen, outstanding;
  int granted_count, nospace_count, range_count;
  int sent_count    = 0;
  int burst_left    = 0;
  int cycle_count   = 0;
  int setting_count = 0;
  bit long_hold     = 1'b0;

  logic [63:0] cur_base  = '0;
  int unsigned cur_pages = 56;

  bitmap_page_allocator_core #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bpa_grant_checker #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) grant_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .results_seen  (results_seen),
    .outstanding   (outstanding),
    .granted_count (granted_count),
    .nospace_count (nospace_count),
    .range_count   (range_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: spans of free flow, light and heavy stalls, plus one long hold-off
  initial begin
    int unsigned mode, span;
    bit          hold_done;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      if (long_hold && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(8, 80);
        repeat (span) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic apb_write(bpa_reg_t idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic configure_region(logic [63:0] base, logic [REG_PAGES_W-1:0] pages);
    apb_write(REG_BASE, base);
    apb_write(REG_PAGES, 64'(pages));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_base  = base;
    cur_pages = (pages > MAX_PAGES) ? MAX_PAGES : pages;
    setting_count++;
  endtask

  task automatic send_req(bpa_cmd_t cmd, logic [31:0] nbytes, logic [63:0] faddr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {faddr, nbytes};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // stop offering and let every open request come back
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (results_seen == sent_count);
  endtask

  task automatic random_req();
    int unsigned kind, pg;
    logic [63:0] faddr, offset, remaining;
    logic [31:0] nbytes;
    kind   = $urandom_range(0, 99);
    faddr  = {$urandom, $urandom};
    nbytes = $urandom;
    if (kind < 45) begin
      if (kind >= 6)
        nbytes = $urandom_range(0, 1) ? 32'($urandom_range(1, 4) * PAGE_BYTES)
                                      : 32'($urandom_range(1, 6 * PAGE_BYTES));
      else if (kind < 3)
        nbytes = '0;
      send_req(CMD_ALLOC, nbytes, faddr);
    end else if (kind < 85 && cur_pages > 0) begin
      pg = $urandom_range(0, cur_pages - 1);
      offset = 64'(pg) * 64'(PAGE_BYTES);
      if ($urandom_range(0, 2) == 0) offset += 64'($urandom_range(0, PAGE_BYTES - 1));
      remaining = 64'(cur_pages) * 64'(PAGE_BYTES) - offset;
      if (kind < 52)
        nbytes = 32'(remaining);          // release everything up to the end
      else if (kind < 55)
        nbytes = 32'(remaining + 1);      // one byte past the end
      else
        nbytes = 32'($urandom_range(0, (remaining < 5 * PAGE_BYTES) ? int'(remaining)
                                                                     : 5 * PAGE_BYTES));
      send_req(CMD_FREE, nbytes, cur_base + offset);
    end else begin
      if ($urandom_range(0, 1)) faddr = cur_base + (faddr & 64'h7_FFFF);
      send_req(bpa_cmd_t'(kind[0]), nbytes, faddr);
    end
  endtask

  initial begin
    int unsigned n_items;
    logic [63:0] base;
    logic [REG_PAGES_W-1:0] phase_pages[8];
    phase_pages = '{7'd64, 7'd1, 7'd127, 7'd3, 7'd0, 7'd56, 7'd17, 7'd65};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, first on the reset settings: base 0, 56 pages
    send_req(CMD_ALLOC, 32'd0, '0);
    send_req(CMD_ALLOC, 32'd1, '0);
    send_req(CMD_ALLOC, 32'(PAGE_BYTES), '0);
    send_req(CMD_ALLOC, 32'(PAGE_BYTES + 1), '0);
    send_req(CMD_ALLOC, 32'hFFFF_FFFF, '1);
    send_req(CMD_ALLOC, 32'(57 * PAGE_BYTES), '0);
    send_req(CMD_FREE, 32'(PAGE_BYTES), 64'(PAGE_BYTES));
    send_req(CMD_ALLOC, 32'(PAGE_BYTES), '0);
    send_req(CMD_FREE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(CMD_FREE, 32'd0, 64'(56 * PAGE_BYTES));
    send_req(CMD_FREE, 32'd1, 64'(56 * PAGE_BYTES));
    send_req(CMD_FREE, 32'(PAGE_BYTES - 100), 64'(55 * PAGE_BYTES + 100));
    send_req(CMD_FREE, 32'(56 * PAGE_BYTES), '0);
    send_req(CMD_ALLOC, 32'(56 * PAGE_BYTES), '0);
    send_req(CMD_ALLOC, 32'd1, '0);
    send_req(CMD_FREE, 32'd8000, 64'd100);
    send_req(CMD_ALLOC, 32'(2 * PAGE_BYTES), '0);
    drain_requests();

    // empty region near the top of the address space
    configure_region(64'hFFFF_FFFF_FFFF_E000, 7'd0);
    send_req(CMD_ALLOC, 32'd1, '0);
    send_req(CMD_FREE, 32'd0, cur_base);
    send_req(CMD_FREE, 32'd1, cur_base);
    send_req(CMD_FREE, 32'd0, cur_base - 1);
    drain_requests();

    // page count above the maximum saturates, grants wrap past the top
    configure_region(64'hFFFF_FFFF_FFFF_C000, 7'd127);
    send_req(CMD_FREE, 32'(MAX_PAGES * PAGE_BYTES), cur_base);
    send_req(CMD_ALLOC, 32'(5 * PAGE_BYTES), '0);
    send_req(CMD_ALLOC, 32'd1, '0);
    send_req(CMD_FREE, 32'd1, cur_base + 64'(5 * PAGE_BYTES));
    drain_requests();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: base = '0;
        1: base = '1;
        default: begin
          base = {$urandom, $urandom};
          if ($urandom_range(0, 1)) base[11:0] = '0;
        end
      endcase
      configure_region(base, phase_pages[phase]);
      n_items = (phase_pages[phase] == 0) ? 15 : 62;
      for (int unsigned k = 0; k < n_items; k++) begin
        if (phase == 2 && k == 20) long_hold = 1'b1;
        random_req();
      end
      drain_requests();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests over %0d region settings: %0d allocations granted,",
             sent_count, setting_count, granted_count);
    $display("%0d refused for space or size, %0d frees outside the region",
             nospace_count, range_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
